// ===== src/pewf_pkg.sv =====
// Package for the particle event window filter.
// Holds field widths, operation codes, the input item type and default sizes.
// No dependencies.
package pewf_pkg;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 2;
    localparam int CODE_W = 24;
    localparam int ETA_W  = 16;
    localparam int PT_W   = 20;
    localparam int MULT_W = 8;

    localparam int DEF_NUM_ENTRIES = 4;
    localparam int DEF_COUNT_BITS  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PARTICLE  = 2'd0,
        OP_LOAD_KIN  = 2'd1,
        OP_LOAD_MULT = 2'd2,
        OP_UNUSED    = 2'd3
    } t_op;

    // One registered input transaction
    typedef struct packed {
        t_op                       op;
        logic [SLOT_W-1:0]         slot;
        logic signed [CODE_W-1:0]  flavour;
        logic signed [ETA_W-1:0]   eta;
        logic signed [ETA_W-1:0]   eta_upper;
        logic [PT_W-1:0]           pt;
        logic [PT_W-1:0]           pt_upper;
        logic [MULT_W-1:0]         count_min;
        logic [MULT_W-1:0]         count_max;
        logic                      entry_enable;
        logic                      final_state;
        logic                      end_of_event;
    } t_item;

endpackage

// ===== src/pewf_crit_table.sv =====
// Criterion table: entry storage, load decode, match counting and event judgment.
// Depends on pewf_pkg.
module pewf_crit_table #(
    parameter int NUM_ENTRIES = pewf_pkg::DEF_NUM_ENTRIES,
    parameter int COUNT_BITS  = pewf_pkg::DEF_COUNT_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  pewf_pkg::t_item i_item,
    output logic           o_event_pass
);
    import pewf_pkg::*;

    localparam int CMP_W = (COUNT_BITS > MULT_W) ? COUNT_BITS : MULT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

    logic                     r_valid   [NUM_ENTRIES];
    logic [CODE_W-1:0]        r_code    [NUM_ENTRIES];
    logic signed [ETA_W-1:0]  r_eta_lo  [NUM_ENTRIES];
    logic signed [ETA_W-1:0]  r_eta_hi  [NUM_ENTRIES];
    logic [PT_W-1:0]          r_pt_lo   [NUM_ENTRIES];
    logic [PT_W-1:0]          r_pt_hi   [NUM_ENTRIES];
    logic [MULT_W-1:0]        r_mult_lo [NUM_ENTRIES];
    logic [MULT_W-1:0]        r_mult_hi [NUM_ENTRIES];
    logic [COUNT_BITS-1:0]    r_count   [NUM_ENTRIES];
    logic [COUNT_BITS-1:0]    n_count   [NUM_ENTRIES];

    logic [NUM_ENTRIES-1:0] hit;
    logic [NUM_ENTRIES-1:0] sel;
    logic [NUM_ENTRIES-1:0] in_win;
    logic                   counted;

    assign counted = (i_item.op == OP_PARTICLE) && i_item.final_state;

    // Compare the particle against every entry in parallel
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            hit[i]    = r_valid[i] && (r_code[i] == i_item.flavour);
            in_win[i] = (i_item.eta >= r_eta_lo[i]) && (i_item.eta <= r_eta_hi[i]) &&
                        (i_item.pt >= r_pt_lo[i]) && (i_item.pt <= r_pt_hi[i]);
        end
    end

    // Pick the lowest enabled entry with the code
    always_comb begin
        logic taken;
        taken = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            sel[i] = hit[i] && !taken;
            taken  = taken || hit[i];
        end
    end

    // Advance counts, saturating
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (counted && sel[i] && in_win[i] && (r_count[i] != COUNT_SAT)) begin
                n_count[i] = r_count[i] + 1'b1;
            end else begin
                n_count[i] = r_count[i];
            end
        end
    end

    // Judge the event on the counts including this particle
    always_comb begin
        logic [CMP_W-1:0] cnt;
        o_event_pass = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            cnt = CMP_W'(n_count[i]);
            if (r_valid[i] && ((cnt == '0) || (cnt < CMP_W'(r_mult_lo[i])) ||
                               (cnt > CMP_W'(r_mult_hi[i])))) begin
                o_event_pass = 1'b0;
            end
        end
    end

    // Hold entries and counts; apply loads and particle updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_valid[i]   <= 1'b0;
                r_code[i]    <= '0;
                r_eta_lo[i]  <= {1'b1, {(ETA_W-1){1'b0}}};
                r_eta_hi[i]  <= {1'b0, {(ETA_W-1){1'b1}}};
                r_pt_lo[i]   <= '0;
                r_pt_hi[i]   <= '1;
                r_mult_lo[i] <= '0;
                r_mult_hi[i] <= '1;
                r_count[i]   <= '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                unique case (i_item.op)
                    OP_PARTICLE: begin
                        r_count[i] <= i_item.end_of_event ? '0 : n_count[i];
                    end
                    OP_LOAD_KIN: begin
                        if (32'(i_item.slot) == i) begin
                            r_code[i]   <= i_item.flavour;
                            r_eta_lo[i] <= i_item.eta;
                            r_eta_hi[i] <= i_item.eta_upper;
                            r_pt_lo[i]  <= i_item.pt;
                            r_pt_hi[i]  <= i_item.pt_upper;
                        end
                    end
                    OP_LOAD_MULT: begin
                        if (32'(i_item.slot) == i) begin
                            r_mult_lo[i] <= i_item.count_min;
                            r_mult_hi[i] <= i_item.count_max;
                            r_valid[i]   <= i_item.entry_enable;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/particle_event_window_filter_unit.sv =====
// Top level of the particle event window filter.
// Depends on pewf_pkg and pewf_crit_table.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one transaction per cycle:
//   a particle (op particle), or a load of an entry's code and kinematic
//   windows, or a load of its multiplicity window and enable bit.
//   Output channel o_out_valid / i_out_ready carries one event_pass result
//   for each particle transaction that has end_of_event set.
//   Path: an accepted transaction is registered in the input register,
//   processed there against all entries in parallel, and its result is
//   loaded into the output register once that register is free.
//   Throughput: one transaction per cycle, unless an end-of-event particle
//   waits behind a stalled result; the compare, count and judge path
//   between input and output registers is combinational.
//   Reset: entries return to their open windows and are disabled, counts
//   clear, both registers empty; the block is ready right after reset.
//   Stall: while a result waits, transactions that give no result keep
//   flowing; an end-of-event particle waits in the input register until
//   the output register frees, and o_in_ready stays low while it waits.
module particle_event_window_filter_unit #(
    parameter int NUM_ENTRIES = pewf_pkg::DEF_NUM_ENTRIES,
    parameter int COUNT_BITS  = pewf_pkg::DEF_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pewf_pkg::OP_W-1:0]           i_op,
    input  logic [pewf_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [pewf_pkg::CODE_W-1:0]  i_flavour,
    input  logic signed [pewf_pkg::ETA_W-1:0]   i_eta,
    input  logic signed [pewf_pkg::ETA_W-1:0]   i_eta_upper,
    input  logic [pewf_pkg::PT_W-1:0]           i_pt,
    input  logic [pewf_pkg::PT_W-1:0]           i_pt_upper,
    input  logic [pewf_pkg::MULT_W-1:0]         i_count_min,
    input  logic [pewf_pkg::MULT_W-1:0]         i_count_max,
    input  logic                                i_entry_enable,
    input  logic                                i_final_state,
    input  logic                                i_end_of_event,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_event_pass
);
    import pewf_pkg::*;

    t_item r_item;
    logic  r_item_valid;
    logic  r_out_valid;
    logic  r_pass;
    logic  n_pass;
    logic  gives_result;
    logic  out_free;
    logic  fire;

    assign gives_result = (r_item.op == OP_PARTICLE) && r_item.end_of_event;
    assign out_free     = !r_out_valid || i_out_ready;
    assign fire         = r_item_valid && (!gives_result || out_free);
    assign o_in_ready   = !r_item_valid || fire;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op           <= t_op'(i_op);
            r_item.slot         <= i_slot;
            r_item.flavour      <= i_flavour;
            r_item.eta          <= i_eta;
            r_item.eta_upper    <= i_eta_upper;
            r_item.pt           <= i_pt;
            r_item.pt_upper     <= i_pt_upper;
            r_item.count_min    <= i_count_min;
            r_item.count_max    <= i_count_max;
            r_item.entry_enable <= i_entry_enable;
            r_item.final_state  <= i_final_state;
            r_item.end_of_event <= i_end_of_event;
        end
    end

    pewf_crit_table #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_item),
        .o_event_pass (n_pass)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && gives_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && gives_result) begin
            r_pass <= n_pass;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_pass = r_pass;

endmodule

// ===== src/pewf_checker.sv =====
// Port-level checks for the particle event window filter, with the bind.
// Depends on pewf_pkg and particle_event_window_filter_unit.
module pewf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [pewf_pkg::OP_W-1:0]           i_op,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_event_pass
);
    import pewf_pkg::*;

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_pass))
        else $error("result changed or dropped while stalled");

    // Input side only blocks behind a stalled output
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked without a stalled result");

    // Reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // A lone load transaction into an idle block gives no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready && (i_op != OP_PARTICLE) ##1
        !i_in_valid && !o_out_valid |=> !o_out_valid)
        else $error("load transaction produced a result");

endmodule

bind particle_event_window_filter_unit pewf_checker u_pewf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_op           (i_op),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_pass   (o_event_pass)
);

// ===== test/particle_event_window_filter_unit_tb.sv =====
// Self-checking testbench for particle_event_window_filter_unit.
// Depends on pewf_pkg and the filter RTL. Holds a scoreboard class that
// predicts each event verdict, plus plain tasks that drive the handshakes.
`timescale 1ns / 1ps

module particle_event_window_filter_unit_tb;
    import pewf_pkg::*;

    localparam int NUM_ENTRIES   = DEF_NUM_ENTRIES;
    localparam int COUNT_BITS    = DEF_COUNT_BITS;
    localparam int COUNT_SAT     = (1 << COUNT_BITS) - 1;
    localparam int PT_ALL_ONES   = (1 << PT_W) - 1;
    localparam int ITEM_TARGET   = 850;
    localparam int SWAP_AT_ITEM  = 320;
    localparam int STEADY_AT     = 600;
    localparam int SAT_AT_ITEM   = 400;
    localparam int HOLD_AT_ITEM  = 650;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int CODE_POOL_N   = 6;

    // Event verdict predictor and in-order store of expected verdicts
    class event_filter_scoreboard;
        bit                        enabled [NUM_ENTRIES];
        logic signed [CODE_W-1:0]  code    [NUM_ENTRIES];
        logic signed [ETA_W-1:0]   eta_lo  [NUM_ENTRIES];
        logic signed [ETA_W-1:0]   eta_hi  [NUM_ENTRIES];
        logic [PT_W-1:0]           pt_lo   [NUM_ENTRIES];
        logic [PT_W-1:0]           pt_hi   [NUM_ENTRIES];
        logic [MULT_W-1:0]         mult_lo [NUM_ENTRIES];
        logic [MULT_W-1:0]         mult_hi [NUM_ENTRIES];
        logic [COUNT_BITS-1:0]     hits    [NUM_ENTRIES];
        bit                        verdict_q[$];
        int errors, loads, particles, ignored, events, passes;

        function new();
            int i;
            for (i = 0; i < NUM_ENTRIES; i++) begin
                enabled[i] = 1'b0;
                code[i]    = '0;
                eta_lo[i]  = ETA_W'(-32768);
                eta_hi[i]  = ETA_W'(32767);
                pt_lo[i]   = '0;
                pt_hi[i]   = '1;
                mult_lo[i] = 8'd0;
                mult_hi[i] = 8'd255;
                hits[i]    = '0;
            end
        endfunction

        // Update the table and counts for one accepted transaction
        function void note_input(t_item it);
            int i;
            bit verdict;
            case (it.op)
                OP_PARTICLE: begin
                    particles++;
                    // lowest enabled entry with the code owns the particle
                    if (it.final_state) begin
                        for (i = 0; i < NUM_ENTRIES; i++) begin
                            if (enabled[i] && code[i] == it.flavour) begin
                                if (it.eta >= eta_lo[i] && it.eta <= eta_hi[i] &&
                                    it.pt >= pt_lo[i] && it.pt <= pt_hi[i] &&
                                    hits[i] < COUNT_SAT)
                                    hits[i]++;
                                break;
                            end
                        end
                    end
                    // judge the event, then clear the counts
                    if (it.end_of_event) begin
                        verdict = 1'b1;
                        for (i = 0; i < NUM_ENTRIES; i++) begin
                            if (enabled[i] && (hits[i] == 0 || hits[i] < mult_lo[i] ||
                                               hits[i] > mult_hi[i]))
                                verdict = 1'b0;
                            hits[i] = '0;
                        end
                        verdict_q.insert(verdict_q.size(), verdict);
                    end
                end
                OP_LOAD_KIN: begin
                    loads++;
                    if (it.slot < NUM_ENTRIES) begin
                        code[it.slot]   = it.flavour;
                        eta_lo[it.slot] = it.eta;
                        eta_hi[it.slot] = it.eta_upper;
                        pt_lo[it.slot]  = it.pt;
                        pt_hi[it.slot]  = it.pt_upper;
                    end
                end
                OP_LOAD_MULT: begin
                    loads++;
                    if (it.slot < NUM_ENTRIES) begin
                        mult_lo[it.slot] = it.count_min;
                        mult_hi[it.slot] = it.count_max;
                        enabled[it.slot] = it.entry_enable;
                    end
                end
                default: ignored++;
            endcase
        endfunction

        // Compare one accepted result with the oldest expected verdict
        function void check_result(logic got);
            bit want;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual event_pass=%0b",
                         $time, got);
                return;
            end
            want = verdict_q.pop_front();
            events++;
            if (want)
                passes++;
            if (got !== want) begin
                errors++;
                $display("%0t: event_pass mismatch, expected %0b, actual %0b",
                         $time, want, got);
            end
        endfunction

        // Flag verdicts that never arrived
        function void final_check();
            while (verdict_q.size() != 0) begin
                errors++;
                $display("%0t: missing result, expected event_pass=%0b, actual none",
                         $time, verdict_q.pop_front());
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_op;
    logic [SLOT_W-1:0]        i_slot;
    logic signed [CODE_W-1:0] i_flavour;
    logic signed [ETA_W-1:0]  i_eta;
    logic signed [ETA_W-1:0]  i_eta_upper;
    logic [PT_W-1:0]          i_pt;
    logic [PT_W-1:0]          i_pt_upper;
    logic [MULT_W-1:0]        i_count_min;
    logic [MULT_W-1:0]        i_count_max;
    logic                     i_entry_enable;
    logic                     i_final_state;
    logic                     i_end_of_event;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_event_pass;

    event_filter_scoreboard sb = new();

    int items_sent  = 0;
    int src_idle    = 37;
    int sink_idle   = 64;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int code_pool [CODE_POOL_N] = '{11, -11, 13, 211, -211, 22};

    particle_event_window_filter_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_flavour      (i_flavour),
        .i_eta          (i_eta),
        .i_eta_upper    (i_eta_upper),
        .i_pt           (i_pt),
        .i_pt_upper     (i_pt_upper),
        .i_count_min    (i_count_min),
        .i_count_max    (i_count_max),
        .i_entry_enable (i_entry_enable),
        .i_final_state  (i_final_state),
        .i_end_of_event (i_end_of_event),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_pass   (o_event_pass)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, sb.pending());
            $display("** particle_event_window_filter_unit: FAILED **");
            $finish;
        end
    end

    // Result side: check accepted results, toggle ready, hold off once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_event_pass);
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.op           = t_op'($urandom_range(3));
        it.slot         = SLOT_W'($urandom);
        it.flavour      = CODE_W'($urandom);
        it.eta          = ETA_W'($urandom);
        it.eta_upper    = ETA_W'($urandom);
        it.pt           = PT_W'($urandom);
        it.pt_upper     = PT_W'($urandom);
        it.count_min    = MULT_W'($urandom);
        it.count_max    = MULT_W'($urandom);
        it.entry_enable = 1'($urandom_range(1));
        it.final_state  = 1'($urandom_range(1));
        it.end_of_event = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_item particle(int code, int eta, int pt, bit fs, bit eoe);
        t_item it;
        it              = rand_item();
        it.op           = OP_PARTICLE;
        it.flavour      = CODE_W'(code);
        it.eta          = ETA_W'(eta);
        it.pt           = PT_W'(pt);
        it.final_state  = fs;
        it.end_of_event = eoe;
        return it;
    endfunction

    function automatic t_item load_kin(int slot, int code, int elo, int ehi, int plo, int phi);
        t_item it;
        it           = rand_item();
        it.op        = OP_LOAD_KIN;
        it.slot      = SLOT_W'(slot);
        it.flavour   = CODE_W'(code);
        it.eta       = ETA_W'(elo);
        it.eta_upper = ETA_W'(ehi);
        it.pt        = PT_W'(plo);
        it.pt_upper  = PT_W'(phi);
        return it;
    endfunction

    function automatic t_item load_mult(int slot, int lo, int hi, bit en);
        t_item it;
        it              = rand_item();
        it.op           = OP_LOAD_MULT;
        it.slot         = SLOT_W'(slot);
        it.count_min    = MULT_W'(lo);
        it.count_max    = MULT_W'(hi);
        it.entry_enable = en;
        return it;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send(input t_item it);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_slot         <= it.slot;
        i_flavour      <= it.flavour;
        i_eta          <= it.eta;
        i_eta_upper    <= it.eta_upper;
        i_pt           <= it.pt;
        i_pt_upper     <= it.pt_upper;
        i_count_min    <= it.count_min;
        i_count_max    <= it.count_max;
        i_entry_enable <= it.entry_enable;
        i_final_state  <= it.final_state;
        i_end_of_event <= it.end_of_event;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
    endtask

    // Rewrite a few entries with mostly reachable windows
    task automatic random_reconfig();
        int n, k, s, lo;
        t_item it;
        n = $urandom_range(3);
        for (k = 0; k <= n; k++) begin
            s       = $urandom_range(NUM_ENTRIES - 1);
            it      = rand_item();
            it.op   = OP_LOAD_KIN;
            it.slot = SLOT_W'(s);
            if ($urandom_range(99) < 80)
                it.flavour = CODE_W'(code_pool[$urandom_range(CODE_POOL_N - 1)]);
            case ($urandom_range(9))
                0, 1: begin
                    it.eta       = ETA_W'(-32768);
                    it.eta_upper = ETA_W'(32767);
                end
                2: ;
                default: begin
                    lo           = rand_between(-3000, 1000);
                    it.eta       = ETA_W'(lo);
                    it.eta_upper = ETA_W'(lo + int'($urandom_range(4000)));
                end
            endcase
            case ($urandom_range(9))
                0, 1: begin
                    it.pt       = '0;
                    it.pt_upper = PT_W'(PT_ALL_ONES);
                end
                2: ;
                default: begin
                    lo          = $urandom_range(5000);
                    it.pt       = PT_W'(lo);
                    it.pt_upper = PT_W'(lo + int'($urandom_range(100000)));
                end
            endcase
            send(it);
            it      = rand_item();
            it.op   = OP_LOAD_MULT;
            it.slot = SLOT_W'(s);
            if ($urandom_range(9) != 0) begin
                lo           = $urandom_range(2);
                it.count_min = MULT_W'(lo);
                it.count_max = MULT_W'(lo + int'($urandom_range(4)));
            end
            it.entry_enable = ($urandom_range(99) < 65);
            send(it);
        end
    endtask

    // One event: particles aimed mostly at enabled entries, end mark last
    task automatic random_event();
        int n, k, s;
        t_item it;
        n = $urandom_range(8);
        for (k = 0; k <= n; k++) begin
            it    = rand_item();
            it.op = OP_PARTICLE;
            s     = $urandom_range(NUM_ENTRIES - 1);
            if ($urandom_range(99) < 70 && sb.enabled[s]) begin
                it.flavour = sb.code[s];
                if ($urandom_range(99) < 80 && sb.eta_lo[s] <= sb.eta_hi[s])
                    it.eta = ETA_W'(rand_between(int'(sb.eta_lo[s]), int'(sb.eta_hi[s])));
                if ($urandom_range(99) < 80 && sb.pt_lo[s] <= sb.pt_hi[s])
                    it.pt = PT_W'(rand_between(int'(sb.pt_lo[s]), int'(sb.pt_hi[s])));
            end else if ($urandom_range(99) < 50) begin
                it.flavour = CODE_W'(code_pool[$urandom_range(CODE_POOL_N - 1)]);
            end
            it.final_state  = ($urandom_range(99) < 85);
            it.end_of_event = (k == n);
            send(it);
        end
    endtask

    // Push one entry's count past its ceiling
    task automatic saturation_event();
        int k;
        send(load_kin(0, 777, -32768, 32767, 0, PT_ALL_ONES));
        send(load_mult(0, 0, 255, 1'b1));
        for (k = 1; k < NUM_ENTRIES; k++)
            send(load_mult(k, 0, 255, 1'b0));
        for (k = 0; k < COUNT_SAT + 5; k++)
            send(particle(777, $urandom, $urandom_range(PT_ALL_ONES), 1'b1,
                          k == COUNT_SAT + 4));
    endtask

    initial begin
        t_item it;
        bit sat_done;
        int r;

        sat_done       = 1'b0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_PARTICLE;
        i_slot         <= '0;
        i_flavour      <= '0;
        i_eta          <= '0;
        i_eta_upper    <= '0;
        i_pt           <= '0;
        i_pt_upper     <= '0;
        i_count_min    <= '0;
        i_count_max    <= '0;
        i_entry_enable <= 1'b0;
        i_final_state  <= 1'b0;
        i_end_of_event <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table passes; unused op and end marks on loads are ignored
        send(particle(-8388608, -32768, 0, 1'b1, 1'b1));
        it              = rand_item();
        it.op           = OP_UNUSED;
        it.end_of_event = 1'b1;
        send(it);
        send(load_kin(0, -8388608, -32768, 32767, 0, PT_ALL_ONES));
        it              = load_mult(0, 0, 255, 1'b1);
        it.end_of_event = 1'b1;
        send(it);
        // zero count fails even with a zero minimum
        send(particle(5, 0, 0, 1'b1, 1'b1));
        send(particle(-8388608, 32767, PT_ALL_ONES, 1'b1, 1'b1));
        // duplicate code: the lower entry takes every match
        send(load_kin(1, 8388607, -100, 100, 10, 20));
        send(load_mult(1, 1, 2, 1'b1));
        send(load_kin(3, 8388607, -32768, 32767, 0, PT_ALL_ONES));
        send(load_mult(3, 0, 255, 1'b1));
        send(particle(-8388608, 0, 0, 1'b1, 1'b0));
        send(particle(8388607, 100, 20, 1'b1, 1'b1));
        send(load_mult(3, 0, 255, 1'b0));
        // window edges, misses, and a non-final particle closing the event
        send(particle(-8388608, -32768, 0, 1'b1, 1'b0));
        send(particle(8388607, -101, 15, 1'b1, 1'b0));
        send(particle(8388607, 0, 21, 1'b1, 1'b0));
        send(particle(8388607, -100, 10, 1'b1, 1'b0));
        send(particle(8388607, 0, 15, 1'b0, 1'b1));
        // count above the multiplicity ceiling
        send(particle(8388607, 0, 15, 1'b1, 1'b0));
        send(particle(8388607, 0, 15, 1'b1, 1'b0));
        send(particle(-8388608, 0, 0, 1'b1, 1'b0));
        send(particle(8388607, 0, 15, 1'b1, 1'b1));
        // inverted window never matches
        send(load_kin(2, 42, 5, -5, 0, PT_ALL_ONES));
        send(load_mult(2, 0, 255, 1'b1));
        send(particle(42, 0, 0, 1'b1, 1'b1));
        send(load_mult(2, 0, 255, 1'b0));

        // random part in three idle phases
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= STEADY_AT) begin
                src_idle  = 0;
                sink_idle = 0;
            end else if (items_sent >= SWAP_AT_ITEM) begin
                src_idle  = 64;
                sink_idle = 37;
            end
            if (!sat_done && items_sent >= SAT_AT_ITEM) begin
                sat_done = 1'b1;
                saturation_event();
            end
            r = $urandom_range(99);
            if (r < 12) begin
                random_reconfig();
            end else if (r < 88) begin
                random_event();
            end else begin
                it = rand_item();
                case ($urandom_range(2))
                    0: it.op = OP_UNUSED;
                    1: it.op = OP_PARTICLE;
                    default: ;
                endcase
                send(it);
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding verdicts, then settle
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.final_check();

        $display("Ran %0d transactions: %0d particles, %0d loads, %0d ignored.",
                 items_sent, sb.particles, sb.loads, sb.ignored);
        $display("Checked %0d event verdicts (%0d passing),", sb.events, sb.passes);
        $display("incl. count saturation and a %0d-cycle output stall.", HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("** particle_event_window_filter_unit: PASSED **");
        end else begin
            $display("** particle_event_window_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule
